@@ rtl/wwts_pkg.sv @@
// ----------------------------------------------------------------------------
// wwts_pkg
// Shared types, codes and constants of the WMM weighted round robin
// transmit scheduler.
// ----------------------------------------------------------------------------
package wwts_pkg;

  localparam int WEIGHT_W    = 8;
  localparam int WMARK_W     = 11;
  localparam int TOTAL_W     = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int NUM_CLASSES = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'h7FF;

  // Transaction kinds.
  localparam logic [2:0] KIND_ENQUEUE = 3'd0;
  localparam logic [2:0] KIND_PICK    = 3'd1;
  localparam logic [2:0] KIND_REQUEUE = 3'd2;
  localparam logic [2:0] KIND_WAKE    = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  // Network layer codes.
  localparam logic [1:0] L3_OTHER = 2'd0;
  localparam logic [1:0] L3_IPV4  = 2'd1;
  localparam logic [1:0] L3_IPV6  = 2'd2;

  // Access classes.
  localparam logic [1:0] CLASS_BK = 2'd0;
  localparam logic [1:0] CLASS_BE = 2'd1;
  localparam logic [1:0] CLASS_VI = 2'd2;
  localparam logic [1:0] CLASS_VO = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_BK  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_BE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_VI  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_VO  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_LEVEL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WAKE_LEVEL = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TX_ENABLED = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] WEIGHT_RESET =
    {8'd4, 8'd3, 8'd2, 8'd1};
  localparam logic [WMARK_W-1:0] STOP_LEVEL_RESET = 11'd512;
  localparam logic [WMARK_W-1:0] WAKE_LEVEL_RESET = 11'd128;

  typedef struct packed {
    logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] weight;
    logic [WMARK_W-1:0]                   stop_level;
    logic [WMARK_W-1:0]                   wake_level;
    logic                                 tx_enabled;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] l3_type;
    logic [7:0] tos_byte;
    logic [2:0] packet_priority;
    logic [1:0] requeue_class;
  } item_t;

  typedef struct packed {
    logic [1:0]         access_class;
    logic               granted;
    logic               stop_event;
    logic               wake_event;
    logic               dropped;
    logic               overflow;
    logic [TOTAL_W-1:0] total_queued;
  } result_t;

  // Priority 1,2 -> BK; 0,3 -> BE; 4,5 -> VI; 6,7 -> VO.
  function automatic logic [1:0] prio_to_class(input logic [2:0] prio);
    logic [1:0] cls;
    case (prio)
      3'd0: cls = CLASS_BE;
      3'd1: cls = CLASS_BK;
      3'd2: cls = CLASS_BK;
      3'd3: cls = CLASS_BE;
      3'd4: cls = CLASS_VI;
      3'd5: cls = CLASS_VI;
      3'd6: cls = CLASS_VO;
      3'd7: cls = CLASS_VO;
      default: cls = CLASS_BE;
    endcase
    return cls;
  endfunction

  // IP frames take the precedence bits of the TOS byte; all others,
  // including the unused layer code, take the packet priority.
  function automatic logic [1:0] classify(input logic [1:0] l3,
                                          input logic [7:0] tos,
                                          input logic [2:0] prio);
    logic [2:0] p;
    p = prio;
    if (l3 == L3_IPV4 || l3 == L3_IPV6) begin
      p = tos[7:5];
    end
    return prio_to_class(p);
  endfunction

endpackage

@@ rtl/wwts_wrr.sv @@
// ----------------------------------------------------------------------------
// wwts_wrr
// Four-way credit scan from the rotating pointer, with a refill pass when
// no class holds both credit and frames.
// ----------------------------------------------------------------------------
module wwts_wrr
  import wwts_pkg::*;
#(
  parameter int CNT_W = 9
) (
  input  logic [1:0]                           start,
  input  logic [NUM_CLASSES-1:0][CNT_W-1:0]    counts,
  input  logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] credits,
  input  logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] weights,
  output logic                                 grant,
  output logic [1:0]                           grant_class,
  output logic [1:0]                           ptr_next,
  output logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] credits_next
);

  logic       hit_credit;
  logic       hit_any;
  logic [1:0] cls_credit;
  logic [1:0] cls_any;
  logic [1:0] idx;

  // First class in rotated order for each of the two passes.
  always_comb begin
    hit_credit = 1'b0;
    hit_any    = 1'b0;
    cls_credit = CLASS_BK;
    cls_any    = CLASS_BK;
    idx        = start;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      idx = start + 2'(i);
      if (!hit_credit && credits[idx] != '0 && counts[idx] != '0) begin
        hit_credit = 1'b1;
        cls_credit = idx;
      end
      if (!hit_any && counts[idx] != '0) begin
        hit_any = 1'b1;
        cls_any = idx;
      end
    end
  end

  always_comb begin
    credits_next = weights;
    grant        = 1'b0;
    grant_class  = CLASS_BE;
    ptr_next     = start;
    if (hit_credit) begin
      credits_next             = credits;
      credits_next[cls_credit] = credits[cls_credit] - WEIGHT_W'(1);
      grant                    = 1'b1;
      grant_class              = cls_credit;
      ptr_next                 = cls_credit + 2'd1;
    end else if (hit_any) begin
      // Refill pass: a zero weight leaves the credit at zero.
      if (weights[cls_any] != '0) begin
        credits_next[cls_any] = weights[cls_any] - WEIGHT_W'(1);
      end
      grant       = 1'b1;
      grant_class = cls_any;
      ptr_next    = cls_any + 2'd1;
    end
  end

endmodule

@@ rtl/wwts_core.sv @@
// ----------------------------------------------------------------------------
// wwts_core
// Scheduler state (class counts, credits, pointer, stopped flag) and the
// single-pass update for one transaction.
// ----------------------------------------------------------------------------
module wwts_core
  import wwts_pkg::*;
#(
  parameter int QUEUE_CAP = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int CNT_W = $clog2(QUEUE_CAP + 1);
  localparam int TOT_W = CNT_W + 2;
  localparam int SUM_W = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;

  logic [NUM_CLASSES-1:0][CNT_W-1:0]    counts;
  logic [NUM_CLASSES-1:0][CNT_W-1:0]    counts_next;
  logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] credits;
  logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] credits_next;
  logic [1:0]                           next_class;
  logic [1:0]                           next_class_next;
  logic                                 stopped;
  logic                                 stopped_next;

  logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] wrr_credits;
  logic                                 wrr_grant;
  logic [1:0]                           wrr_class;
  logic [1:0]                           wrr_ptr;

  logic [SUM_W-1:0] total_cur;
  logic [SUM_W-1:0] total_after;
  logic [1:0]       enq_class;

  wwts_wrr #(
    .CNT_W(CNT_W)
  ) u_wrr (
    .start       (next_class),
    .counts      (counts),
    .credits     (credits),
    .weights     (cfg.weight),
    .grant       (wrr_grant),
    .grant_class (wrr_class),
    .ptr_next    (wrr_ptr),
    .credits_next(wrr_credits)
  );

  assign total_cur = SUM_W'(counts[0]) + SUM_W'(counts[1])
                   + SUM_W'(counts[2]) + SUM_W'(counts[3]);
  assign enq_class = classify(item.l3_type, item.tos_byte, item.packet_priority);

  always_comb begin
    counts_next     = counts;
    credits_next    = credits;
    next_class_next = next_class;
    stopped_next    = stopped;
    total_after     = total_cur;
    res             = '0;
    case (item.kind)
      KIND_ENQUEUE: begin
        res.access_class = enq_class;
        if (!cfg.tx_enabled) begin
          res.dropped = 1'b1;
        end else if (counts[enq_class] >= CNT_W'(QUEUE_CAP)) begin
          res.overflow = 1'b1;
        end else begin
          counts_next[enq_class] = counts[enq_class] + CNT_W'(1);
          total_after            = total_cur + SUM_W'(1);
          if (total_after >= SUM_W'(cfg.stop_level) && !stopped) begin
            stopped_next   = 1'b1;
            res.stop_event = 1'b1;
          end
        end
      end
      KIND_PICK: begin
        credits_next     = wrr_credits;
        next_class_next  = wrr_ptr;
        res.access_class = wrr_class;
        if (wrr_grant) begin
          counts_next[wrr_class] = counts[wrr_class] - CNT_W'(1);
          total_after            = total_cur - SUM_W'(1);
          res.granted            = 1'b1;
        end
      end
      KIND_REQUEUE: begin
        res.access_class = item.requeue_class;
        if (counts[item.requeue_class] >= CNT_W'(QUEUE_CAP)) begin
          res.overflow = 1'b1;
        end else begin
          counts_next[item.requeue_class] = counts[item.requeue_class] + CNT_W'(1);
          total_after                     = total_cur + SUM_W'(1);
        end
      end
      KIND_WAKE: begin
        if (total_cur <= SUM_W'(cfg.wake_level) && stopped) begin
          stopped_next   = 1'b0;
          res.wake_event = 1'b1;
        end
      end
      KIND_FLUSH: begin
        counts_next = '0;
        total_after = '0;
      end
      default: begin
      end
    endcase
    res.total_queued = (total_after > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                         : total_after[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts     <= '0;
      credits    <= WEIGHT_RESET;
      next_class <= CLASS_VO;
      stopped    <= 1'b0;
    end else if (fire) begin
      counts     <= counts_next;
      credits    <= credits_next;
      next_class <= next_class_next;
      stopped    <= stopped_next;
    end
  end

endmodule

@@ rtl/wmm_wrr_tx_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// wmm_wrr_tx_scheduler_top
// WMM transmit scheduler: per-class frame counts, weighted round robin
// pick, and stop/wake flow control against two watermarks.
// ----------------------------------------------------------------------------
// The scheduler takes one transaction per clock while in_stall is low and
// returns exactly one result transaction for each, in order. A transaction
// is first captured in the input register; then the classification, the
// four-way credit scan and the count update run in one pass and land in
// the result register once it can take a result, while the next
// transaction is already being captured. The credit scan over the four
// classes and the count adder set the path length between these two
// registers. The output register lets a finished result wait under stall
// while one more transaction is held at the input; in_stall rises only
// when both are occupied. The configuration registers are written through
// the plain write port and should be changed only when no transaction is
// in flight. QUEUE_CAP sets the per-class capacity and thereby the width
// of the class counters.
// ----------------------------------------------------------------------------
module wmm_wrr_tx_scheduler_top
  import wwts_pkg::*;
#(
  parameter int QUEUE_CAP = 256
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             kind,
  input  logic [1:0]             l3_type,
  input  logic [7:0]             tos_byte,
  input  logic [2:0]             packet_priority,
  input  logic [1:0]             requeue_class,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             access_class,
  output logic                   granted,
  output logic                   stop_event,
  output logic                   wake_event,
  output logic                   dropped,
  output logic                   overflow,
  output logic [TOTAL_W-1:0]     total_queued
);

  cfg_t    cfg;
  item_t   item;
  logic    item_full;
  result_t res;
  result_t res_reg;
  logic    advance;
  logic    fire;

  // Configuration registers. Indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight     <= WEIGHT_RESET;
      cfg.stop_level <= STOP_LEVEL_RESET;
      cfg.wake_level <= WAKE_LEVEL_RESET;
      cfg.tx_enabled <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_BK:  cfg.weight[CLASS_BK] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_BE:  cfg.weight[CLASS_BE] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_VI:  cfg.weight[CLASS_VI] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_VO:  cfg.weight[CLASS_VO] <= cfg_data[WEIGHT_W-1:0];
        REG_STOP_LEVEL: cfg.stop_level       <= cfg_data[WMARK_W-1:0];
        REG_WAKE_LEVEL: cfg.wake_level       <= cfg_data[WMARK_W-1:0];
        REG_TX_ENABLED: cfg.tx_enabled       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The result register can take a new result when it is empty or its
  // current transaction is leaving in this cycle.
  assign advance  = !out_valid || !out_stall;
  assign fire     = item_full && advance;
  assign in_stall = item_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (!in_stall) begin
      item_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item.kind            <= kind;
      item.l3_type         <= l3_type;
      item.tos_byte        <= tos_byte;
      item.packet_priority <= packet_priority;
      item.requeue_class   <= requeue_class;
    end
  end

  wwts_core #(
    .QUEUE_CAP(QUEUE_CAP)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .item(item),
    .cfg (cfg),
    .res (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= res;
    end
  end

  assign access_class = res_reg.access_class;
  assign granted      = res_reg.granted;
  assign stop_event   = res_reg.stop_event;
  assign wake_event   = res_reg.wake_event;
  assign dropped      = res_reg.dropped;
  assign overflow     = res_reg.overflow;
  assign total_queued = res_reg.total_queued;

endmodule
